// ----- hw/rtl/ssba_pkg.sv -----
// ----------------------------------------------------------------------------
// ssba_pkg
// Shared types, codes and helpers of the swap slot bitmap allocator.
// ----------------------------------------------------------------------------
package ssba_pkg;

  localparam int SEC_W     = 13;  // sector address width
  localparam int CFG_W     = 11;  // slot count register width
  localparam int STATUS_W  = 2;
  localparam int WORD_BITS = 64;  // slots held in one map row
  localparam int BIT_W     = 6;   // bit index within a row

  localparam int MAX_SLOTS_DEF        = 1024;
  localparam int SECTORS_PER_SLOT_DEF = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

  typedef struct packed {
    logic             operation;
    logic [SEC_W-1:0] sector_address;
  } in_item_t;

  typedef struct packed {
    logic [SEC_W-1:0]    allocated_sector;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC_MUL,
    ST_FREE_QUO,
    ST_FREE_MUL,
    ST_FREE_CHK,
    ST_DONE
  } state_t;

  // Lowest clear bit of a row, found by halving the window six times.
  // Only meaningful when the row has a clear bit.
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] word);
    logic [WORD_BITS-1:0] v;
    logic [BIT_W-1:0]     idx;
    v   = ~word;
    idx = '0;
    for (int lvl = BIT_W - 1; lvl >= 0; lvl--) begin
      if ((v & ((WORD_BITS'(1) << (1 << lvl)) - WORD_BITS'(1))) == '0) begin
        v        = v >> (1 << lvl);
        idx[lvl] = 1'b1;
      end
    end
    return idx;
  endfunction

endpackage

// ----- hw/rtl/ssba_map.sv -----
// ----------------------------------------------------------------------------
// ssba_map
// Slot usage map: one synchronous row memory with registered read data and
// a clearing sweep after reset, one row per cycle.
// ----------------------------------------------------------------------------
module ssba_map #(
  parameter int WORDS = 16,
  parameter int AW    = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [AW-1:0]                  rd_addr,
  output logic [ssba_pkg::WORD_BITS-1:0] rd_data,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [ssba_pkg::WORD_BITS-1:0] wr_data,
  output logic                           busy
);

  logic [ssba_pkg::WORD_BITS-1:0] mem [WORDS];
  logic [ssba_pkg::WORD_BITS-1:0] rd_data_r;
  logic [AW-1:0]                  clr_idx_r;
  logic                           busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else if (busy_r) begin
      if (clr_idx_r == AW'(WORDS - 1)) begin
        busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

// ----- hw/rtl/swap_slot_bitmap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// swap_slot_bitmap_allocator_top
// First-fit swap slot allocator over a bitmap of page-sized slots.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, in_data): an allocate or a free request.
// Result channel (out_valid/out_ready, out_data): one result per request,
// in request order. cfg_wr_en/cfg_wr_data write the slot count; write it
// only while no request is outstanding.
// The map lives in a row memory of 64 slots per row, with registered read
// data. Allocate reads rows in order, one per cycle, until a row with a
// free slot below the slot count turns up, reading at most ceil(count/64)
// rows, 16 at the defaults; with none it answers full, and a slot count of
// zero reads no row.
// Free divides by the slot size with a reciprocal multiply, reads the row,
// checks and writes back.
// One request is in work at a time; the next is taken once the previous
// result is in the output register, so a stalled receiver holds one result
// while one more request completes behind it.
// After reset the map is swept clear, one row per cycle; in_ready stays low
// meanwhile.
// ----------------------------------------------------------------------------
module swap_slot_bitmap_allocator_top #(
  parameter int MAX_SLOTS        = ssba_pkg::MAX_SLOTS_DEF,
  parameter int SECTORS_PER_SLOT = ssba_pkg::SECTORS_PER_SLOT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ssba_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ssba_pkg::out_item_t          out_data,
  input  logic                         cfg_wr_en,
  input  logic [ssba_pkg::CFG_W-1:0]   cfg_wr_data
);

  localparam int WB        = ssba_pkg::WORD_BITS;
  localparam int BW        = ssba_pkg::BIT_W;
  localparam int SEC_W     = ssba_pkg::SEC_W;
  localparam int NUM_WORDS = (MAX_SLOTS + WB - 1) / WB;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SLOT_W    = WIDX_W + BW;
  localparam int ISS_W     = $clog2(NUM_WORDS + 1);
  localparam int CNT_W     = (SEC_W > $clog2(MAX_SLOTS + 1)) ? SEC_W : $clog2(MAX_SLOTS + 1);
  localparam int SPS_W     = $clog2(SECTORS_PER_SLOT + 1);
  localparam int DIV_SH    = SEC_W + $clog2(SECTORS_PER_SLOT);
  localparam int RECIP     = ((1 << DIV_SH) + SECTORS_PER_SLOT - 1) / SECTORS_PER_SLOT;
  localparam int RECIP_W   = SEC_W + 2;
  localparam int PROD_W    = SEC_W + RECIP_W;
  localparam int FB_W      = SEC_W + SPS_W;
  localparam int SP_W      = SLOT_W + SPS_W;

  ssba_pkg::state_t    state_r, state_nxt;
  logic [SEC_W-1:0]    sector_r, sector_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [SEC_W-1:0]    q_r, q_nxt;
  logic [FB_W-1:0]     base_r, base_nxt;
  logic [ISS_W-1:0]    issue_r, issue_nxt;
  logic                pend_r, pend_nxt;
  logic [WIDX_W-1:0]   pidx_r, pidx_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  ssba_pkg::out_item_t res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  ssba_pkg::out_item_t out_data_r, out_data_nxt;
  logic [ssba_pkg::CFG_W-1:0] cfg_slots_r;

  logic [WIDX_W-1:0]   rd_addr;
  logic [WB-1:0]       rd_data;
  logic                wr_en;
  logic [WIDX_W-1:0]   wr_addr;
  logic [WB-1:0]       wr_data;
  logic                map_busy;

  logic [CNT_W-1:0]    n_act;
  logic [CNT_W-1:0]    words_act;
  logic                can_issue;
  logic [CNT_W-1:0]    row_base;
  logic [CNT_W-1:0]    row_lim;
  logic [WB-1:0]       avail;
  logic [WB-1:0]       busy_word;
  logic                hit;
  logic [BW-1:0]       hit_bit;
  logic [CNT_W-1:0]    q_ext;
  logic [WIDX_W-1:0]   q_row;
  logic [BW-1:0]       q_bit;
  logic                q_ok;
  logic [SP_W-1:0]     alloc_prod;

  ssba_map #(
    .WORDS (NUM_WORDS),
    .AW    (WIDX_W)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .busy    (map_busy)
  );

  // Active slot count, saturated to the map size
  assign n_act = (CNT_W'(cfg_slots_r) > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                            : CNT_W'(cfg_slots_r);
  assign words_act = (n_act + CNT_W'(WB - 1)) >> BW;
  assign can_issue = CNT_W'(issue_r) < words_act;

  // Slots at or above the count look used, so the scan never picks them
  assign row_base  = CNT_W'({pidx_r, {BW{1'b0}}});
  assign row_lim   = n_act - row_base;
  assign avail     = (row_lim >= CNT_W'(WB)) ? '1 : ((WB'(1) << row_lim) - WB'(1));
  assign busy_word = rd_data | ~avail;
  assign hit       = pend_r && (busy_word != '1);
  assign hit_bit   = ssba_pkg::first_zero(busy_word);

  assign q_ext = CNT_W'(q_r);
  assign q_row = q_ext[SLOT_W-1:BW];
  assign q_bit = q_ext[BW-1:0];
  assign q_ok  = (q_ext < n_act) && (base_r == FB_W'(sector_r)) && rd_data[q_bit];

  assign alloc_prod = SP_W'(slot_r) * SP_W'(SECTORS_PER_SLOT);

  assign in_ready  = (state_r == ssba_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    sector_nxt    = sector_r;
    prod_nxt      = prod_r;
    q_nxt         = q_r;
    base_nxt      = base_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    slot_nxt      = slot_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_addr       = issue_r[WIDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = pidx_r;
    wr_data       = rd_data | (WB'(1) << hit_bit);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ssba_pkg::ST_CLEAR: begin
        if (!map_busy) begin
          state_nxt = ssba_pkg::ST_IDLE;
        end
      end
      ssba_pkg::ST_IDLE: begin
        if (in_valid) begin
          sector_nxt = in_data.sector_address;
          prod_nxt   = PROD_W'(in_data.sector_address) * PROD_W'(RECIP);
          issue_nxt  = '0;
          pend_nxt   = 1'b0;
          if (in_data.operation == ssba_pkg::OP_FREE) begin
            state_nxt = ssba_pkg::ST_FREE_QUO;
          end else begin
            state_nxt = ssba_pkg::ST_SCAN;
          end
        end
      end
      ssba_pkg::ST_SCAN: begin
        // Issue the next row while the previous one is checked
        pend_nxt = 1'b0;
        if (can_issue) begin
          issue_nxt = issue_r + ISS_W'(1);
          pend_nxt  = 1'b1;
          pidx_nxt  = issue_r[WIDX_W-1:0];
        end
        if (hit) begin
          wr_en     = 1'b1;
          slot_nxt  = {pidx_r, hit_bit};
          state_nxt = ssba_pkg::ST_ALLOC_MUL;
        end else if (!pend_r && !can_issue) begin
          res_nxt.allocated_sector = '0;
          res_nxt.status           = ssba_pkg::STATUS_FULL;
          state_nxt                = ssba_pkg::ST_DONE;
        end
      end
      ssba_pkg::ST_ALLOC_MUL: begin
        res_nxt.allocated_sector = SEC_W'(alloc_prod);
        res_nxt.status           = ssba_pkg::STATUS_OK;
        state_nxt                = ssba_pkg::ST_DONE;
      end
      ssba_pkg::ST_FREE_QUO: begin
        q_nxt     = SEC_W'(prod_r >> DIV_SH);
        state_nxt = ssba_pkg::ST_FREE_MUL;
      end
      ssba_pkg::ST_FREE_MUL: begin
        base_nxt  = FB_W'(q_r) * FB_W'(SECTORS_PER_SLOT);
        rd_addr   = q_row;
        state_nxt = ssba_pkg::ST_FREE_CHK;
      end
      ssba_pkg::ST_FREE_CHK: begin
        res_nxt.allocated_sector = '0;
        wr_addr                  = q_row;
        wr_data                  = rd_data & ~(WB'(1) << q_bit);
        if (q_ok) begin
          wr_en          = 1'b1;
          res_nxt.status = ssba_pkg::STATUS_OK;
        end else begin
          res_nxt.status = ssba_pkg::STATUS_BAD;
        end
        state_nxt = ssba_pkg::ST_DONE;
      end
      ssba_pkg::ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ssba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ssba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssba_pkg::ST_CLEAR;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_slots_r <= ssba_pkg::CFG_RESET;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_slots_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    sector_r   <= sector_nxt;
    prod_r     <= prod_nxt;
    q_r        <= q_nxt;
    base_r     <= base_nxt;
    pidx_r     <= pidx_nxt;
    slot_r     <= slot_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_scan_write_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == ssba_pkg::ST_SCAN) |-> pend_r)
    else $error("allocation write without row data");

  a_alloc_sets_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == ssba_pkg::ST_SCAN) |->
      ($countones(wr_data ^ rd_data) == 1 && (rd_data & ~wr_data) == '0))
    else $error("allocation must set exactly one bit");

  a_free_clears_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == ssba_pkg::ST_FREE_CHK) |->
      ($countones(wr_data ^ rd_data) == 1 && (wr_data & ~rd_data) == '0))
    else $error("free must clear exactly one bit");

  a_alloc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ssba_pkg::ST_ALLOC_MUL) |-> (CNT_W'(slot_r) < n_act))
    else $error("allocated slot beyond slot count");

  a_transfer_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ssba_pkg::ST_IDLE && state_r != ssba_pkg::ST_CLEAR))
    else $error("request transfer did not start work");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit swap slot allocator.
// A directed table walks the corner cases: reset state, lowest-free search,
// bad frees, zero and saturated slot counts, a full map and a lowered count.
// Random traffic then leans to allocation, then to freeing, under a series of slot
// counts. Every result is compared with a bit-level predictor of the map.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_SLOTS    = ssba_pkg::MAX_SLOTS_DEF;
  localparam int SLOT_SECTORS = ssba_pkg::SECTORS_PER_SLOT_DEF;
  localparam int SEC_W        = ssba_pkg::SEC_W;
  localparam int CFG_W        = ssba_pkg::CFG_W;
  localparam int STATUS_W     = ssba_pkg::STATUS_W;
  localparam int IDLE_LIMIT   = 4000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 100;
  localparam int PHASE_ITEMS  = 138;
  localparam int NUM_PHASES   = 12;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t           kind;
    ssba_pkg::in_item_t  req;
    logic [CFG_W-1:0]    cfg;
    bit                  typed;
    ssba_pkg::out_item_t result;
  } stim_row_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  ssba_pkg::in_item_t  in_data     = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  ssba_pkg::out_item_t out_data;
  logic                cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;

  // Typed expectation travelling alongside the request payload
  bit                  stim_typed  = 1'b0;
  ssba_pkg::out_item_t stim_result = '0;

  // Predictor state
  bit                  slot_map [MAX_SLOTS];
  logic [CFG_W-1:0]    slot_count = ssba_pkg::CFG_RESET;
  ssba_pkg::out_item_t pending_results [$];

  stim_row_t           directed_rows [$];
  int                  errors      = 0;
  int unsigned         burst_left  = 0;
  int unsigned         idle_cycles = 0;

  // Receiver pattern state
  int unsigned         sink_cycle  = 0;
  int unsigned         sink_mode   = 0;
  int unsigned         mode_left   = 0;
  int unsigned         hold_left   = 0;

  swap_slot_bitmap_allocator_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned active_slot_count();
    return (slot_count > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
  endfunction

  // First-fit allocate or checked free against the shadow map
  function automatic ssba_pkg::out_item_t predict_slot_op(ssba_pkg::in_item_t req);
    ssba_pkg::out_item_t res;
    int unsigned         n;
    int unsigned         slot;
    n = active_slot_count();
    res.allocated_sector = '0;
    if (req.operation == ssba_pkg::OP_ALLOC) begin
      res.status = ssba_pkg::STATUS_FULL;
      for (int s = 0; s < n; s++) begin
        if (!slot_map[s]) begin
          slot_map[s]          = 1'b1;
          res.allocated_sector = SEC_W'(s * SLOT_SECTORS);
          res.status           = ssba_pkg::STATUS_OK;
          break;
        end
      end
    end else begin
      slot = req.sector_address / SLOT_SECTORS;
      if ((req.sector_address % SLOT_SECTORS) != 0 || slot >= n || !slot_map[slot]) begin
        res.status = ssba_pkg::STATUS_BAD;
      end else begin
        slot_map[slot] = 1'b0;
        res.status     = ssba_pkg::STATUS_OK;
      end
    end
    return res;
  endfunction

  // Mostly frees of live slots; the rest misaligned, stale or out of range
  function automatic logic [SEC_W-1:0] free_target();
    int unsigned n;
    int unsigned pick;
    int unsigned start;
    int unsigned s;
    n     = active_slot_count();
    pick  = $urandom_range(0, 9);
    start = $urandom_range(0, MAX_SLOTS - 1);
    if (pick <= 6) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        s = (start + i) % MAX_SLOTS;
        if (slot_map[s] && s < n) return SEC_W'(s * SLOT_SECTORS);
      end
    end
    if (pick == 7) return SEC_W'($urandom_range(0, (1 << SEC_W) - 1));
    if (pick == 9 && n > 0) return SEC_W'((n - 1 + $urandom_range(0, 1)) * SLOT_SECTORS);
    return SEC_W'(start * SLOT_SECTORS);
  endfunction

  function automatic void add_req(logic op, int sector, bit typed, int exp_sector,
                                  logic [STATUS_W-1:0] exp_status);
    stim_row_t row;
    row.kind                    = ROW_REQ;
    row.req.operation           = op;
    row.req.sector_address      = SEC_W'(sector);
    row.cfg                     = '0;
    row.typed                   = typed;
    row.result.allocated_sector = SEC_W'(exp_sector);
    row.result.status           = exp_status;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(int value);
    stim_row_t row;
    row.kind   = ROW_CFG;
    row.req    = '0;
    row.cfg    = CFG_W'(value);
    row.typed  = 1'b0;
    row.result = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void report_mismatch(string field, int exp_val, int act_val);
    errors++;
    if (errors <= REPORT_LIMIT)
      $error("%s mismatch: expected %0d, got %0d", field, exp_val, act_val);
  endfunction

  // Bursts of back-to-back requests with idle gaps between them
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 15);
    gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic offer_request(ssba_pkg::in_item_t req, bit typed,
                               ssba_pkg::out_item_t result);
    in_valid    <= 1'b1;
    in_data     <= req;
    stim_typed  <= typed;
    stim_result <= result;
    do @(posedge clk); while (!in_ready);
    pace_sender();
  endtask

  // Write the slot count once every outstanding result has come back
  task automatic write_slot_count(logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Scoreboard: predict on request transfer, compare on result transfer
  always @(posedge clk) begin : scoreboard
    ssba_pkg::out_item_t want;
    ssba_pkg::out_item_t got;
    if (cfg_wr_en) slot_count = cfg_wr_data;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $error("result with nothing outstanding: sector %0d status %0d",
                 out_data.allocated_sector, out_data.status);
      end else begin
        want = pending_results.pop_front();
        if (out_data.allocated_sector !== want.allocated_sector)
          report_mismatch("allocated_sector", want.allocated_sector,
                          out_data.allocated_sector);
        if (out_data.status !== want.status)
          report_mismatch("status", want.status, out_data.status);
      end
    end
    if (in_valid && in_ready) begin
      got = predict_slot_op(in_data);
      pending_results.push_back(stim_typed ? stim_result : got);
    end
  end

  // Receiver: shifting stall pattern plus two long hold-offs to back up the input
  always @(posedge clk) begin
    sink_cycle <= sink_cycle + 1;
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (sink_cycle == 5000 || sink_cycle == 20000) begin
      out_ready <= 1'b0;
      hold_left <= 400;
    end else begin
      if (mode_left == 0) begin
        sink_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (sink_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 0);
        2: out_ready <= ($urandom_range(0, 4) != 0);
        default: out_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned        phase_counts [NUM_PHASES];
    int unsigned        count;
    ssba_pkg::in_item_t req;
    phase_counts = '{64, 65, 1, 2047, 130, 0, 63, 1024, 7, 0, 200, 1024};

    // Slots 0..2 taken, slot 1 freed, then stale and misaligned frees at the reset count
    add_req(ssba_pkg::OP_ALLOC, 0,    1, 0,  ssba_pkg::STATUS_OK);
    add_req(ssba_pkg::OP_ALLOC, 8191, 1, 8,  ssba_pkg::STATUS_OK);
    add_req(ssba_pkg::OP_ALLOC, 0,    1, 16, ssba_pkg::STATUS_OK);
    add_req(ssba_pkg::OP_FREE,  8,    1, 0,  ssba_pkg::STATUS_OK);
    add_req(ssba_pkg::OP_FREE,  8,    1, 0,  ssba_pkg::STATUS_BAD);
    add_req(ssba_pkg::OP_FREE,  3,    1, 0,  ssba_pkg::STATUS_BAD);
    add_req(ssba_pkg::OP_FREE,  8191, 1, 0,  ssba_pkg::STATUS_BAD);
    add_req(ssba_pkg::OP_FREE,  8184, 1, 0,  ssba_pkg::STATUS_BAD);
    add_req(ssba_pkg::OP_ALLOC, 0,    1, 8,  ssba_pkg::STATUS_OK);
    // Lowered count: slot 1 keeps its bit but lies out of range
    add_cfg(1);
    add_req(ssba_pkg::OP_FREE,  8,    1, 0,  ssba_pkg::STATUS_BAD);
    add_req(ssba_pkg::OP_ALLOC, 0,    1, 0,  ssba_pkg::STATUS_FULL);
    add_req(ssba_pkg::OP_FREE,  0,    1, 0,  ssba_pkg::STATUS_OK);
    add_req(ssba_pkg::OP_ALLOC, 0,    1, 0,  ssba_pkg::STATUS_OK);
    add_cfg(0);
    add_req(ssba_pkg::OP_ALLOC, 0,    1, 0,  ssba_pkg::STATUS_FULL);
    add_req(ssba_pkg::OP_FREE,  0,    1, 0,  ssba_pkg::STATUS_BAD);
    // Register above the slot store saturates
    add_cfg(2047);
    add_req(ssba_pkg::OP_FREE,  8,    1, 0,  ssba_pkg::STATUS_OK);
    add_req(ssba_pkg::OP_ALLOC, 0,    1, 8,  ssba_pkg::STATUS_OK);
    add_req(ssba_pkg::OP_FREE,  8184, 1, 0,  ssba_pkg::STATUS_BAD);
    add_req(ssba_pkg::OP_ALLOC, 0,    1, 24, ssba_pkg::STATUS_OK);
    add_req(ssba_pkg::OP_ALLOC, 8191, 0, 0,  ssba_pkg::STATUS_OK);
    add_req(ssba_pkg::OP_FREE,  32,   0, 0,  ssba_pkg::STATUS_OK);
    // Four slots, all used: the map is full
    add_cfg(4);
    add_req(ssba_pkg::OP_ALLOC, 0,    1, 0,  ssba_pkg::STATUS_FULL);
    add_req(ssba_pkg::OP_FREE,  16,   1, 0,  ssba_pkg::STATUS_OK);
    add_req(ssba_pkg::OP_ALLOC, 0,    1, 16, ssba_pkg::STATUS_OK);
    add_req(ssba_pkg::OP_FREE,  4096, 1, 0,  ssba_pkg::STATUS_BAD);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_slot_count(directed_rows[i].cfg);
      else
        offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].result);
    end

    // Each phase favours allocations in its first half and frees in its second
    for (int p = 0; p < NUM_PHASES; p++) begin
      count = (p == 9) ? $urandom_range(0, (1 << CFG_W) - 1) : phase_counts[p];
      write_slot_count(CFG_W'(count));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        req.operation = ($urandom_range(0, 99) < ((k < PHASE_ITEMS / 2) ? 70 : 30))
                        ? ssba_pkg::OP_ALLOC : ssba_pkg::OP_FREE;
        req.sector_address = (req.operation == ssba_pkg::OP_ALLOC)
                             ? SEC_W'($urandom_range(0, (1 << SEC_W) - 1)) : free_target();
        offer_request(req, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
